### design/vtri_pkg.sv
// Shared types and constants of the video terminal register interface.
// Depends on nothing; vtri_regs and the top level use it by scoped names.
package vtri_pkg;

    // Item function codes; the codes five to seven are unused.
    typedef enum logic [2:0] {
        FUNC_READ  = 3'd0,
        FUNC_WRITE = 3'd1,
        FUNC_KEY   = 3'd2,
        FUNC_BLINK = 3'd3,
        FUNC_FETCH = 3'd4
    } vtri_func_t;

    // Bus bit offsets on page 0.
    localparam logic [3:0] OFF_STORE    = 4'd8;
    localparam logic [3:0] OFF_MOVE     = 4'd10;
    localparam logic [3:0] OFF_BLINK_EN = 4'd11;
    localparam logic [3:0] OFF_IRQ_EN   = 4'd12;
    localparam logic [3:0] OFF_DUAL     = 4'd13;
    localparam logic [3:0] OFF_SHOW     = 4'd14;

    // Bus bit offsets on page 1.
    localparam logic [3:0] OFF_CURSOR_TOP = 4'd10;
    localparam logic [3:0] OFF_CURSOR_SHOW = 4'd12;
    localparam logic [3:0] OFF_KEY_ACK    = 4'd13;
    localparam logic [3:0] OFF_BEEP       = 4'd14;

    // Page switch, valid on both pages.
    localparam logic [3:0] OFF_PAGE = 4'd15;

    // Configuration register indexes.
    localparam logic CFG_LARGE_SCREEN = 1'b0;
    localparam logic CFG_EIGHT_BIT    = 1'b1;

    // Cursor masks and code mask.
    localparam logic [10:0] CURSOR_MASK_SMALL = 11'h3ff;
    localparam logic [10:0] CURSOR_MASK_LARGE = 11'h7ff;
    localparam logic [7:0]  CODE_MASK_7       = 8'h7f;

    // Side information carried from the accept cycle to the result cycle.
    typedef struct packed {
        logic       rd_from_mem;
        logic [7:0] rd_imm;
        logic       fetch;
        logic       shown;
        logic       dual;
        logic       eight;
        logic       hit;
        logic       irq;
        logic       beep;
    } vtri_side_t;

endpackage

### design/vtri_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module vtri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/vtri_regs.sv
// Control registers, bus decode and memory request generation.
// Depends on vtri_pkg.
module vtri_regs #(
    parameter int SCREEN_BYTES = 2048
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            go,
    input  logic [2:0]                      func,
    input  logic [3:0]                      bit_offset,
    input  logic                            bit_value,
    input  logic [7:0]                      key_code,
    input  logic [10:0]                     cell_address,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic                            cfg_data,
    output logic                            mem_we,
    output logic [$clog2(SCREEN_BYTES)-1:0] mem_waddr,
    output logic [7:0]                      mem_wdata,
    output logic [$clog2(SCREEN_BYTES)-1:0] mem_raddr,
    output logic                            done,
    output vtri_pkg::vtri_side_t            side
);

    localparam int AW = $clog2(SCREEN_BYTES);

    // Reduce an 11-bit address modulo the screen size; for a size of 1024 or more
    // the value stays below twice the size, so one compare and subtract is enough.
    function automatic logic [AW-1:0] mem_index(input logic [10:0] a);
        logic [11:0] wide;
        begin
            wide = {1'b0, a};
            if (wide >= 12'(SCREEN_BYTES))
            begin
                wide = wide - 12'(SCREEN_BYTES);
            end
            return wide[AW-1:0];
        end
    endfunction

    logic        large_screen_reg;
    logic        eight_bit_reg;
    logic [7:0]  write_byte_reg, write_byte_next;
    logic [10:0] cursor_reg, cursor_next;
    logic [7:0]  key_latch_reg, key_latch_next;
    logic        key_ready_reg, key_ready_next;
    logic        irq_en_reg, irq_en_next;
    logic        show_reg, show_next;
    logic        dual_reg, dual_next;
    logic        cursor_shown_reg, cursor_shown_next;
    logic        blinks_reg, blinks_next;
    logic        phase_reg, phase_next;
    logic        page_reg, page_next;
    logic        prior_page_reg, prior_page_next;
    logic        done_reg;
    vtri_pkg::vtri_side_t side_reg, side_next;
    logic [10:0] cursor_mask;

    assign cursor_mask = large_screen_reg ? vtri_pkg::CURSOR_MASK_LARGE
                                          : vtri_pkg::CURSOR_MASK_SMALL;

    // Memory addresses: a fetch reads its cell, everything else the cursor.
    assign mem_raddr = (vtri_pkg::vtri_func_t'(func) == vtri_pkg::FUNC_FETCH)
                       ? mem_index(cell_address) : mem_index(cursor_reg);
    assign mem_waddr = mem_index(cursor_reg);
    assign mem_wdata = write_byte_reg;

    // Decode of one item and next-state logic.
    always_comb
    begin
        logic [10:0] cursor_bits;
        cursor_bits       = cursor_reg;
        write_byte_next   = write_byte_reg;
        cursor_next       = cursor_reg;
        key_latch_next    = key_latch_reg;
        key_ready_next    = key_ready_reg;
        irq_en_next       = irq_en_reg;
        show_next         = show_reg;
        dual_next         = dual_reg;
        cursor_shown_next = cursor_shown_reg;
        blinks_next       = blinks_reg;
        phase_next        = phase_reg;
        page_next         = page_reg;
        prior_page_next   = prior_page_reg;
        side_next         = '0;
        mem_we            = 1'b0;
        if (go)
        begin
            unique case (vtri_pkg::vtri_func_t'(func))
                vtri_pkg::FUNC_READ:
                begin
                    if (!page_reg)
                    begin
                        if (!bit_offset[0])
                        begin
                            side_next.rd_from_mem = 1'b1;
                        end
                        else
                        begin
                            side_next.rd_imm = {key_ready_reg, key_latch_reg[6:0]};
                        end
                    end
                    else if (!bit_offset[0])
                    begin
                        side_next.rd_imm = cursor_reg[7:0];
                    end
                    else
                    begin
                        side_next.rd_imm = {key_ready_reg, 1'b0, prior_page_reg, 1'b0,
                                            key_latch_reg[7], cursor_reg[10:8]};
                    end
                end
                vtri_pkg::FUNC_WRITE:
                begin
                    if (bit_offset == vtri_pkg::OFF_PAGE)
                    begin
                        prior_page_next = page_reg;
                        page_next       = bit_value;
                    end
                    else if (!page_reg)
                    begin
                        // Page 0: data byte, store, cursor move and enables.
                        if (!bit_offset[3])
                        begin
                            write_byte_next[bit_offset[2:0]] = bit_value;
                        end
                        else if (bit_offset == vtri_pkg::OFF_STORE)
                        begin
                            mem_we = 1'b1;
                        end
                        else if (bit_offset == vtri_pkg::OFF_MOVE)
                        begin
                            cursor_next = (bit_value ? cursor_reg - 11'd1
                                                     : cursor_reg + 11'd1) & cursor_mask;
                        end
                        else if (bit_offset == vtri_pkg::OFF_BLINK_EN)
                        begin
                            blinks_next = bit_value;
                        end
                        else if (bit_offset == vtri_pkg::OFF_IRQ_EN)
                        begin
                            irq_en_next = bit_value;
                        end
                        else if (bit_offset == vtri_pkg::OFF_DUAL)
                        begin
                            dual_next = bit_value;
                        end
                        else if (bit_offset == vtri_pkg::OFF_SHOW)
                        begin
                            show_next = bit_value;
                        end
                    end
                    else
                    begin
                        // Page 1: cursor bits, cursor show, key ack and beep.
                        if (bit_offset <= vtri_pkg::OFF_CURSOR_TOP)
                        begin
                            cursor_bits[bit_offset] = bit_value;
                            cursor_next = cursor_bits & cursor_mask;
                        end
                        else if (bit_offset == vtri_pkg::OFF_CURSOR_SHOW)
                        begin
                            cursor_shown_next = bit_value;
                        end
                        else if (bit_offset == vtri_pkg::OFF_KEY_ACK)
                        begin
                            key_ready_next = 1'b0;
                        end
                        else if (bit_offset == vtri_pkg::OFF_BEEP)
                        begin
                            side_next.beep = 1'b1;
                        end
                    end
                end
                vtri_pkg::FUNC_KEY:
                begin
                    if (!key_ready_reg)
                    begin
                        key_latch_next = key_code;
                        key_ready_next = 1'b1;
                    end
                end
                vtri_pkg::FUNC_BLINK:
                begin
                    phase_next = ~phase_reg;
                end
                vtri_pkg::FUNC_FETCH:
                begin
                    side_next.fetch = 1'b1;
                    side_next.shown = show_reg;
                    side_next.dual  = dual_reg;
                    side_next.eight = eight_bit_reg;
                    side_next.hit   = (cell_address == cursor_reg) && cursor_shown_reg
                                      && (!blinks_reg || phase_reg);
                end
                default:
                begin
                    side_next.rd_imm = '0;
                end
            endcase
        end
        side_next.irq = irq_en_next && key_ready_next;
    end

    // State registers and configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            large_screen_reg <= 1'b1;
            eight_bit_reg    <= 1'b0;
            write_byte_reg   <= '0;
            cursor_reg       <= '0;
            key_latch_reg    <= '0;
            key_ready_reg    <= 1'b0;
            irq_en_reg       <= 1'b0;
            show_reg         <= 1'b0;
            dual_reg         <= 1'b0;
            cursor_shown_reg <= 1'b0;
            blinks_reg       <= 1'b0;
            phase_reg        <= 1'b0;
            page_reg         <= 1'b0;
            prior_page_reg   <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == vtri_pkg::CFG_LARGE_SCREEN)
                begin
                    large_screen_reg <= cfg_data;
                end
                else
                begin
                    eight_bit_reg <= cfg_data;
                end
            end
            write_byte_reg   <= write_byte_next;
            cursor_reg       <= cursor_next;
            key_latch_reg    <= key_latch_next;
            key_ready_reg    <= key_ready_next;
            irq_en_reg       <= irq_en_next;
            show_reg         <= show_next;
            dual_reg         <= dual_next;
            cursor_shown_reg <= cursor_shown_next;
            blinks_reg       <= blinks_next;
            phase_reg        <= phase_next;
            page_reg         <= page_next;
            prior_page_reg   <= prior_page_next;
            done_reg         <= go;
        end
    end

    // Side information for the result beat.
    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
    end

    assign done = done_reg;
    assign side = side_reg;

endmodule

### design/video_terminal_register_interface_top.sv
// Top level of the video terminal register interface.
// Depends on vtri_pkg, vtri_ram and vtri_regs.
//
//   Channel   Handshake        Payload
//   --------  ---------------  ---------------------------------------------------
//   item in   start / busy     func, bit_offset, bit_value, key_code, cell_address
//   result    done (strobe)    read_data, cell_code, cell_colour, screen_blank,
//                              irq_level, beep_start
//   config    cfg_write        cfg_index, cfg_data
//
// One item is taken per cycle while busy is low; its result beat appears in the
// cycle after it is accepted, set by the registered read of the display memory.
// After reset, busy stays high while the display memory is cleared one cell a
// cycle; configuration writes are taken then too.
// The receiver cannot stall: each result beat is on the ports for one cycle.
module video_terminal_register_interface_top #(
    parameter int SCREEN_BYTES = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [3:0]  bit_offset,
    input  logic        bit_value,
    input  logic [7:0]  key_code,
    input  logic [10:0] cell_address,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic        cfg_data,
    output logic        done,
    output logic [7:0]  read_data,
    output logic [7:0]  cell_code,
    output logic [1:0]  cell_colour,
    output logic        screen_blank,
    output logic        irq_level,
    output logic        beep_start
);

    localparam int AW = $clog2(SCREEN_BYTES);

    logic                 go;
    logic                 clearing_reg;
    logic [AW-1:0]        clr_addr_reg;
    logic                 regs_we;
    logic [AW-1:0]        regs_waddr;
    logic [7:0]           regs_wdata;
    logic [AW-1:0]        ram_raddr;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [7:0]           ram_wdata;
    logic [7:0]           ram_rdata;
    logic [7:0]           code_masked;
    logic                 fetch_shown;
    vtri_pkg::vtri_side_t side;

    assign busy = clearing_reg;
    assign go   = start && !busy;

    // Clearing sweep of the display memory after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(SCREEN_BYTES - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    vtri_regs #(
        .SCREEN_BYTES(SCREEN_BYTES)
    ) u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (go),
        .func         (func),
        .bit_offset   (bit_offset),
        .bit_value    (bit_value),
        .key_code     (key_code),
        .cell_address (cell_address),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mem_we       (regs_we),
        .mem_waddr    (regs_waddr),
        .mem_wdata    (regs_wdata),
        .mem_raddr    (ram_raddr),
        .done         (done),
        .side         (side)
    );

    // Write port: the clearing sweep owns it until it ends.
    assign ram_we    = clearing_reg || regs_we;
    assign ram_waddr = clearing_reg ? clr_addr_reg : regs_waddr;
    assign ram_wdata = clearing_reg ? 8'd0 : regs_wdata;

    vtri_ram #(
        .WIDTH(8),
        .DEPTH(SCREEN_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result assembly from the memory word and the side information.
    assign fetch_shown  = side.fetch && side.shown;
    assign code_masked  = side.eight ? ram_rdata : (ram_rdata & vtri_pkg::CODE_MASK_7);
    assign read_data    = side.rd_from_mem ? ram_rdata : side.rd_imm;
    assign cell_code    = fetch_shown ? code_masked : 8'd0;
    assign cell_colour  = {fetch_shown && side.hit, fetch_shown && side.dual && ram_rdata[7]};
    assign screen_blank = side.fetch && !side.shown;
    assign irq_level    = side.irq;
    assign beep_start   = side.beep;

    // Every accepted item gives its result beat in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) go |=> done)
        else $error("accepted item gave no result beat");

    // A result beat only follows an accepted item.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(go))
        else $error("result beat without an accepted item");

    // The clearing sweep writes memory in every cycle that it runs.
    assert property (@(posedge clk) disable iff (!rst_n) clearing_reg |-> ram_we)
        else $error("clearing sweep skipped a cell");

    // The beep pulse and a blanked fetch only show on a result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (beep_start || screen_blank) |-> done)
        else $error("result field set outside a result beat");

endmodule
